[rtl/ffjp_pkg.sv]
// Package with the shared widths, codes and control types of the first-fit job placer.
`timescale 1ns / 1ps
`default_nettype none
package ffjp_pkg;

  localparam int MAX_WORKERS = 128;
  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W = $clog2(MAX_WORKERS + 1);

  localparam int CORES_W = 8;
  localparam int MEM_W = 12;
  localparam int TIME_W = 16;
  localparam int BUSY_W = 17;
  localparam int TAG_W = 16;
  localparam int WIDX_W = 7;
  localparam int WIU_W = 8;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [WIU_W-1:0] RESET_WORKERS = 8'd128;
  localparam logic [CORES_W-1:0] RESET_CORES = 8'd24;
  localparam logic [MEM_W-1:0] RESET_MEMORY = 12'd64;

  localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORES_PER_WORKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_PER_WORKER = 2'd2;

  localparam logic CMD_RELOAD = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  typedef struct packed {
    logic [CORES_W-1:0] cores;
    logic [MEM_W-1:0] mem;
    logic [BUSY_W-1:0] busy;
  } entry_t;

  typedef struct packed {
    logic cmd;
    logic [TIME_W-1:0] arrival_time;
    logic [CORES_W-1:0] cores_needed;
    logic [MEM_W-1:0] memory_needed;
    logic [TIME_W-1:0] run_length;
    logic [TAG_W-1:0] job_tag;
  } job_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag_out;
    logic placed;
    logic [WIDX_W-1:0] worker_index;
    logic [BUSY_W-1:0] finish_time;
  } res_t;

  typedef struct packed {
    logic start;
    logic reload_en;
    logic scan_en;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic reload_done;
    logic hit;
    logic miss_done;
    logic out_free;
  } ctl_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RELOAD = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

[rtl/ffjp_ifs.sv]
// Channel interfaces for jobs, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface ffjp_job_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [ffjp_pkg::TIME_W-1:0] arrival_time;
  logic [ffjp_pkg::CORES_W-1:0] cores_needed;
  logic [ffjp_pkg::MEM_W-1:0] memory_needed;
  logic [ffjp_pkg::TIME_W-1:0] run_length;
  logic [ffjp_pkg::TAG_W-1:0] job_tag;

  modport source (output valid, cmd, arrival_time, cores_needed, memory_needed, run_length,
                  job_tag, input ready);
  modport sink (input valid, cmd, arrival_time, cores_needed, memory_needed, run_length,
                job_tag, output ready);
endinterface

interface ffjp_res_if;
  logic valid;
  logic ready;
  logic [ffjp_pkg::TAG_W-1:0] tag_out;
  logic placed;
  logic [ffjp_pkg::WIDX_W-1:0] worker_index;
  logic [ffjp_pkg::BUSY_W-1:0] finish_time;

  modport source (output valid, tag_out, placed, worker_index, finish_time, input ready);
  modport sink (input valid, tag_out, placed, worker_index, finish_time, output ready);
endinterface

interface ffjp_cfg_if;
  logic valid;
  logic ready;
  logic [ffjp_pkg::CFG_IDX_W-1:0] index;
  logic [ffjp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/ffjp_datapath.sv]
// Datapath with configuration registers, worker table, scan counter and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ffjp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ffjp_pkg::job_t                job_in,
  input  wire logic                          cfg_we,
  input  wire logic [ffjp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ffjp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire ffjp_pkg::ctl_cmd_t            cmd,
  output ffjp_pkg::ctl_stat_t                stat,
  output ffjp_pkg::res_t                     out_res,
  output logic                               out_vld,
  input  wire logic                          out_rdy
);
  import ffjp_pkg::*;

  logic [WIU_W-1:0] workers_in_use;
  logic [CORES_W-1:0] cores_per_worker;
  logic [MEM_W-1:0] memory_per_worker;

  job_t item;
  logic [CNT_W-1:0] n_act;
  logic [CNT_W-1:0] rd_idx;
  logic chk_vld;
  logic [IDX_W-1:0] chk_idx;
  entry_t rd_ent;
  logic rd_valid;
  res_t res;

  entry_t tbl [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] vld_bits;

  entry_t cur;
  entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [BUSY_W-1:0] fin;
  logic [CNT_W-1:0] n_calc;
  logic fit, hit, in_range, issue, reload_wr, wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      workers_in_use <= RESET_WORKERS;
      cores_per_worker <= RESET_CORES;
      memory_per_worker <= RESET_MEMORY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WORKERS_IN_USE: workers_in_use <= cfg_data[WIU_W-1:0];
        REG_CORES_PER_WORKER: cores_per_worker <= cfg_data[CORES_W-1:0];
        REG_MEMORY_PER_WORKER: memory_per_worker <= cfg_data[MEM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_calc = (32'(workers_in_use) > MAX_WORKERS) ? CNT_W'(MAX_WORKERS)
                                                 : CNT_W'(workers_in_use);
    rd_addr = rd_idx[IDX_W-1:0];
    cur = rd_valid ? rd_ent : entry_t'{cores: RESET_CORES, mem: RESET_MEMORY, busy: '0};
    fin = BUSY_W'(item.arrival_time) + BUSY_W'(item.run_length);
    fit = (cur.cores >= item.cores_needed) && (cur.mem >= item.memory_needed) &&
          (cur.busy <= BUSY_W'(item.arrival_time));
    hit = cmd.scan_en && chk_vld && fit;
    in_range = rd_idx < n_act;
    issue = cmd.scan_en && in_range && !hit;
    reload_wr = cmd.reload_en && in_range;
    wr_en = reload_wr || hit;
    wr_addr = hit ? chk_idx : rd_addr;
    if (hit) begin
      wr_data.cores = cur.cores - item.cores_needed;
      wr_data.mem = cur.mem - item.memory_needed;
      wr_data.busy = fin;
    end else begin
      wr_data.cores = cores_per_worker;
      wr_data.mem = memory_per_worker;
      wr_data.busy = '0;
    end
    stat.reload_done = !in_range;
    stat.hit = hit;
    stat.miss_done = cmd.scan_en && !chk_vld && !in_range;
    stat.out_free = !out_vld || out_rdy;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_ent <= tbl[rd_addr];
      rd_valid <= vld_bits[rd_addr];
      chk_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_bits <= '0;
      rd_idx <= '0;
      chk_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_bits[wr_addr] <= 1'b1;
      end
      if (cmd.start) begin
        rd_idx <= '0;
      end else if (issue || reload_wr) begin
        rd_idx <= CNT_W'(rd_idx + 1'b1);
      end
      if (cmd.start) begin
        chk_vld <= 1'b0;
      end else if (cmd.scan_en) begin
        chk_vld <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item <= job_in;
      n_act <= n_calc;
      res.tag_out <= job_in.job_tag;
      res.placed <= 1'b0;
      res.worker_index <= '0;
      res.finish_time <= '0;
    end else if (hit) begin
      res.placed <= 1'b1;
      res.worker_index <= WIDX_W'(chk_idx);
      res.finish_time <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld <= 1'b1;
    end else if (out_rdy) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

[rtl/ffjp_controller.sv]
// Controller state machine that sequences reload sweeps, table scans and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ffjp_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  output logic                     in_ready,
  input  wire ffjp_pkg::ctl_stat_t stat,
  output ffjp_pkg::ctl_cmd_t       cmd
);
  import ffjp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = (in_cmd == CMD_PLACE) ? ST_SCAN : ST_RELOAD;
        end
      end
      ST_RELOAD: begin
        cmd.reload_en = 1'b1;
        if (stat.reload_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.hit || stat.miss_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/first_fit_job_placer.sv]
// Top level of the first-fit job placer: channels, controller and datapath.
//
// The jobs channel takes one transaction per command. A reload command sets every
// worker in use back to the configured cores and memory and clears its busy time.
// A place command scans the workers in use in index order and takes the first that
// fits. Every command yields one transaction on the results channel.
// The number of workers scanned or reloaded is workers_in_use capped at 128. The
// scan reads one table entry per cycle through the single registered read port of
// the worker table. One command is in work at a time; the next one is accepted as
// soon as its predecessor's result sits in the output register.
// If the receiver stalls, the result is held and at most one further command
// completes its work before the block stops accepting.
// Reset clears the configuration to 128 workers, 24 cores and 64 memory units, and
// marks all table entries as holding their reset contents; no sweep is needed.
// Configuration writes are taken in any cycle and should occur only when idle.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_job_placer (
  input  wire logic clk,
  input  wire logic rst,
  ffjp_job_if.sink   jobs,
  ffjp_res_if.source results,
  ffjp_cfg_if.sink   cfg
);
  import ffjp_pkg::*;

  job_t job_in;
  res_t out_res;
  ctl_cmd_t cmd;
  ctl_stat_t stat;
  logic out_vld;

  assign job_in.cmd = jobs.cmd;
  assign job_in.arrival_time = jobs.arrival_time;
  assign job_in.cores_needed = jobs.cores_needed;
  assign job_in.memory_needed = jobs.memory_needed;
  assign job_in.run_length = jobs.run_length;
  assign job_in.job_tag = jobs.job_tag;

  assign cfg.ready = 1'b1;

  ffjp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (jobs.valid),
    .in_cmd   (jobs.cmd),
    .in_ready (jobs.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffjp_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .job_in   (job_in),
    .cfg_we   (cfg.valid),
    .cfg_idx  (cfg.index),
    .cfg_data (cfg.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_res  (out_res),
    .out_vld  (out_vld),
    .out_rdy  (results.ready)
  );

  assign results.valid = out_vld;
  assign results.tag_out = out_res.tag_out;
  assign results.placed = out_res.placed;
  assign results.worker_index = out_res.worker_index;
  assign results.finish_time = out_res.finish_time;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (jobs.valid && jobs.ready) |=> !jobs.ready)
    else $error("Block accepted a second transaction while one was in work.");

  a_pending_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.placed) |->
      (results.worker_index == '0 && results.finish_time == '0))
    else $error("Unplaced result carries a worker index or finish time.");

  a_scan_end_unique: assert property (@(posedge clk) disable iff (rst)
    !(stat.hit && stat.miss_done))
    else $error("Scan reported both a hit and exhaustion.");

  a_ops_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan_en && cmd.reload_en))
    else $error("Scan and reload sweep active together.");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("Output register overwritten while its result was pending.");

endmodule
`default_nettype wire
